FILE: rtl/aabb_pkg.sv
// Shared constants for the box collision resolve unit.
`timescale 1ns / 1ps

package aabb_pkg;

    localparam int PUSH_BITS = 16;
    localparam int DIR_BITS  = 3;

    typedef logic [DIR_BITS-1:0] dir_code_t;

    localparam dir_code_t DIR_NONE    = 3'd0;
    localparam dir_code_t DIR_PLUS_X  = 3'd1;
    localparam dir_code_t DIR_MINUS_X = 3'd2;
    localparam dir_code_t DIR_PLUS_Y  = 3'd3;
    localparam dir_code_t DIR_MINUS_Y = 3'd4;

endpackage

FILE: rtl/aabb_collision_resolve_unit.sv
// Top level of the box collision resolve unit: a four-stage pipeline.
`timescale 1ns / 1ps
// An accepted transaction passes the stage 1, stage 2 and stage 3 registers, then the output register, to out_valid.
// Throughput: one transaction per cycle; each stage holds only while the one after it is full.
// The last stage is the output register; a waiting result stalls earlier stages only once
// every stage behind it is full, so bubbles still close up.
// Reset: rst_n clears all stage valid bits asynchronously; payload registers keep no reset.

module aabb_collision_resolve_unit #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [COORD_BITS-1:0]         this_center_x,
    input  logic signed [COORD_BITS-1:0]         this_center_y,
    input  logic        [COORD_BITS-2:0]         this_half_w,
    input  logic        [COORD_BITS-2:0]         this_half_h,
    input  logic signed [COORD_BITS-1:0]         other_center_x,
    input  logic signed [COORD_BITS-1:0]         other_center_y,
    input  logic        [COORD_BITS-2:0]         other_half_w,
    input  logic        [COORD_BITS-2:0]         other_half_h,
    input  logic signed [aabb_pkg::PUSH_BITS-1:0] push_weight,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 hit,
    output logic signed [COORD_BITS+1:0]         this_move_x,
    output logic signed [COORD_BITS+1:0]         this_move_y,
    output logic signed [COORD_BITS+1:0]         other_move_x,
    output logic signed [COORD_BITS+1:0]         other_move_y,
    output aabb_pkg::dir_code_t                  direction_code
);

    localparam int DW = COORD_BITS + 1;   // center delta width
    localparam int MW = COORD_BITS + 2;   // overlap and move width
    localparam int WP = FRAC_BITS + 1;    // clamped weight width, holds 1.0
    localparam int PE = aabb_pkg::PUSH_BITS + 2;

    localparam logic [WP-1:0] ONE_Q     = WP'(1) << FRAC_BITS;
    localparam logic [PE-1:0] ONE_WIDE  = PE'(1) << FRAC_BITS;

    // Each stage advances when it is empty or the stage after it moves.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4     = !v4_reg || out_ready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;
    assign out_valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Stage 1: center deltas, summed half sizes and the clamped push weight.
    logic signed [DW-1:0]         dx_next, dy_next, dx_reg, dy_reg;
    logic [COORD_BITS-1:0]        sum_w_next, sum_h_next, sum_w_reg, sum_h_reg;
    logic signed [PE-1:0]         push_wide;
    logic [WP-1:0]                p1_next, k1_next, p1_reg, k1_reg;

    assign dx_next = DW'(other_center_x) - DW'(this_center_x);
    assign dy_next = DW'(other_center_y) - DW'(this_center_y);
    assign sum_w_next = COORD_BITS'(this_half_w) + COORD_BITS'(other_half_w);
    assign sum_h_next = COORD_BITS'(this_half_h) + COORD_BITS'(other_half_h);
    assign push_wide  = PE'(push_weight);

    always_comb
    begin
        if (push_wide < 0)
        begin
            p1_next = '0;
        end
        else if (push_wide > $signed(ONE_WIDE))
        begin
            p1_next = ONE_Q;
        end
        else
        begin
            p1_next = push_wide[WP-1:0];
        end
        k1_next = ONE_Q - p1_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            sum_w_reg <= sum_w_next;
            sum_h_reg <= sum_h_next;
            p1_reg    <= p1_next;
            k1_reg    <= k1_next;
        end
    end

    // Stage 2: overlap value per axis, |d| minus the summed half sizes.
    // It is negative when the boxes intersect along that axis.
    logic signed [MW-1:0] dx_ext, dy_ext, abs_dx, abs_dy;
    logic signed [MW-1:0] ix_next, iy_next, ix_reg, iy_reg;
    logic                 dx_pos_reg, dy_pos_reg;
    logic [WP-1:0]        p2_reg, k2_reg;

    assign dx_ext  = MW'(dx_reg);
    assign dy_ext  = MW'(dy_reg);
    assign abs_dx  = dx_reg[DW-1] ? -dx_ext : dx_ext;
    assign abs_dy  = dy_reg[DW-1] ? -dy_ext : dy_ext;
    assign ix_next = abs_dx - $signed(MW'(sum_w_reg));
    assign iy_next = abs_dy - $signed(MW'(sum_h_reg));

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            ix_reg     <= ix_next;
            iy_reg     <= iy_next;
            // A zero delta counts as the minus side.
            dx_pos_reg <= !dx_reg[DW-1] && (dx_reg != '0);
            dy_pos_reg <= !dy_reg[DW-1] && (dy_reg != '0);
            p2_reg     <= p1_reg;
            k2_reg     <= k1_reg;
        end
    end

    // Stage 3: hit test, axis choice (ties go to y) and the signed overlap.
    logic                 hit_next, axis_y_next;
    logic signed [MW-1:0] ovl_next;
    aabb_pkg::dir_code_t  dir_next;
    logic                 hit3_reg, axis_y_reg;
    logic signed [MW-1:0] ovl_reg;
    aabb_pkg::dir_code_t  dir3_reg;
    logic [WP-1:0]        p3_reg, k3_reg;

    always_comb
    begin
        hit_next    = ix_reg[MW-1] && iy_reg[MW-1];
        axis_y_next = !(ix_reg > iy_reg);
        if (axis_y_next)
        begin
            ovl_next = dy_pos_reg ? iy_reg : -iy_reg;
            dir_next = dy_pos_reg ? aabb_pkg::DIR_PLUS_Y : aabb_pkg::DIR_MINUS_Y;
        end
        else
        begin
            ovl_next = dx_pos_reg ? ix_reg : -ix_reg;
            dir_next = dx_pos_reg ? aabb_pkg::DIR_PLUS_X : aabb_pkg::DIR_MINUS_X;
        end
        if (!hit_next)
        begin
            dir_next = aabb_pkg::DIR_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            hit3_reg   <= hit_next;
            axis_y_reg <= axis_y_next;
            ovl_reg    <= ovl_next;
            dir3_reg   <= dir_next;
            p3_reg     <= p2_reg;
            k3_reg     <= k2_reg;
        end
    end

    // Stage 4: the two scaling multiplies feed the output register.
    logic signed [MW-1:0] this_mv, other_mv;

    aabb_split #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_split (
        .overlap    (ovl_reg),
        .keep       (k3_reg),
        .push       (p3_reg),
        .this_move  (this_mv),
        .other_move (other_mv)
    );

    logic                 hit_reg;
    logic signed [MW-1:0] tmx_reg, tmy_reg, omx_reg, omy_reg;
    aabb_pkg::dir_code_t  dir_reg;

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            hit_reg <= hit3_reg;
            dir_reg <= dir3_reg;
            // Only the chosen axis moves, and only on a hit.
            tmx_reg <= (hit3_reg && !axis_y_reg) ? this_mv  : '0;
            omx_reg <= (hit3_reg && !axis_y_reg) ? other_mv : '0;
            tmy_reg <= (hit3_reg && axis_y_reg)  ? this_mv  : '0;
            omy_reg <= (hit3_reg && axis_y_reg)  ? other_mv : '0;
        end
    end

    assign hit            = hit_reg;
    assign this_move_x    = tmx_reg;
    assign this_move_y    = tmy_reg;
    assign other_move_x   = omx_reg;
    assign other_move_y   = omy_reg;
    assign direction_code = dir_reg;

endmodule

FILE: rtl/aabb_split.sv
// Overlap split: scales the signed overlap by the keep and push shares.
`timescale 1ns / 1ps

module aabb_split #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 8
) (
    input  logic signed [COORD_BITS+1:0] overlap,
    input  logic        [FRAC_BITS:0]    keep,
    input  logic        [FRAC_BITS:0]    push,
    output logic signed [COORD_BITS+1:0] this_move,
    output logic signed [COORD_BITS+1:0] other_move
);

    localparam int MW = COORD_BITS + 2;
    localparam int PW = COORD_BITS + FRAC_BITS + 4;

    logic signed [PW-1:0] ovl_ext;
    logic signed [PW-1:0] neg_ext;
    logic signed [PW-1:0] keep_ext;
    logic signed [PW-1:0] push_ext;
    logic signed [PW-1:0] prod_keep;
    logic signed [PW-1:0] prod_push;

    // The overlap magnitude stays below 2^COORD_BITS, so its negation fits.
    assign ovl_ext  = PW'(overlap);
    assign neg_ext  = -ovl_ext;
    assign keep_ext = $signed(PW'(keep));
    assign push_ext = $signed(PW'(push));

    assign prod_keep = ovl_ext * keep_ext;
    assign prod_push = neg_ext * push_ext;

    // Dropping the low fraction bits of a two's complement product floors it.
    assign this_move  = prod_keep[FRAC_BITS +: MW];
    assign other_move = prod_push[FRAC_BITS +: MW];

endmodule

FILE: tb/aabb_collision_resolve_unit_tb.sv
// Self-checking testbench for the box collision resolve unit, with random handshakes.
`timescale 1ns / 1ps

module aabb_collision_resolve_unit_tb;

    localparam int COORD_BITS   = 24;
    localparam int FRAC_BITS    = 8;
    localparam int MOVE_BITS    = COORD_BITS + 2;
    localparam longint UNIT_W   = longint'(1) << FRAC_BITS;
    localparam int RANDOM_PAIRS = 1350;
    localparam int IDLE_PCT     = 6;
    // Both sides run without idling inside this window of cycles.
    localparam int QUIET_FROM   = 200;
    localparam int QUIET_TO     = 700;
    // Four pipeline stages plus some margin for the final settling pause.
    localparam int TAIL_CYCLES  = 16;
    localparam int CYCLE_LIMIT  = 200000;

    // One input transaction: two boxes and the push weight.
    // Setting wait_idle makes the driver hold it back until every result is in.
    typedef struct {
        logic signed [COORD_BITS-1:0]          t_cx;
        logic signed [COORD_BITS-1:0]          t_cy;
        logic        [COORD_BITS-2:0]          t_hw;
        logic        [COORD_BITS-2:0]          t_hh;
        logic signed [COORD_BITS-1:0]          o_cx;
        logic signed [COORD_BITS-1:0]          o_cy;
        logic        [COORD_BITS-2:0]          o_hw;
        logic        [COORD_BITS-2:0]          o_hh;
        logic signed [aabb_pkg::PUSH_BITS-1:0] push;
        bit                                    wait_idle;
    } box_pair_t;

    // One output transaction: the separation of the two boxes.
    typedef struct {
        logic                        hit;
        logic signed [MOVE_BITS-1:0] t_mx;
        logic signed [MOVE_BITS-1:0] t_my;
        logic signed [MOVE_BITS-1:0] o_mx;
        logic signed [MOVE_BITS-1:0] o_my;
        aabb_pkg::dir_code_t         dir;
    } separation_t;

    // Every input starts at a known value; reset is the only thing held at time zero.
    logic                                  clk            = 1'b0;
    logic                                  rst_n          = 1'b0;
    logic                                  in_valid       = 1'b0;
    logic                                  in_ready;
    logic signed [COORD_BITS-1:0]          this_center_x  = '0;
    logic signed [COORD_BITS-1:0]          this_center_y  = '0;
    logic        [COORD_BITS-2:0]          this_half_w    = '0;
    logic        [COORD_BITS-2:0]          this_half_h    = '0;
    logic signed [COORD_BITS-1:0]          other_center_x = '0;
    logic signed [COORD_BITS-1:0]          other_center_y = '0;
    logic        [COORD_BITS-2:0]          other_half_w   = '0;
    logic        [COORD_BITS-2:0]          other_half_h   = '0;
    logic signed [aabb_pkg::PUSH_BITS-1:0] push_weight    = '0;
    logic                                  out_valid;
    logic                                  out_ready      = 1'b0;
    logic                                  hit;
    logic signed [MOVE_BITS-1:0]           this_move_x;
    logic signed [MOVE_BITS-1:0]           this_move_y;
    logic signed [MOVE_BITS-1:0]           other_move_x;
    logic signed [MOVE_BITS-1:0]           other_move_y;
    aabb_pkg::dir_code_t                   direction_code;

    box_pair_t   pending_pairs[$];
    separation_t expected_moves[$];
    box_pair_t   driven_pair;
    int          mismatch_count = 0;
    int          cycle_count    = 0;

    aabb_collision_resolve_unit #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .this_center_x  (this_center_x),
        .this_center_y  (this_center_y),
        .this_half_w    (this_half_w),
        .this_half_h    (this_half_h),
        .other_center_x (other_center_x),
        .other_center_y (other_center_y),
        .other_half_w   (other_half_w),
        .other_half_h   (other_half_h),
        .push_weight    (push_weight),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hit            (hit),
        .this_move_x    (this_move_x),
        .this_move_y    (this_move_y),
        .other_move_x   (other_move_x),
        .other_move_y   (other_move_y),
        .direction_code (direction_code)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Expected separation for one box pair. All arithmetic runs in 64 bits so that
    // nothing overflows; the moves are cut to the port width only at the end.
    function automatic separation_t resolve_pair(box_pair_t p);
        separation_t r;
        longint      dx;
        longint      dy;
        longint      ov_x;
        longint      ov_y;
        longint      share;
        longint      keep;
        longint      signed_ov;
        longint      mv_this;
        longint      mv_other;
        dx = longint'(p.o_cx) - longint'(p.t_cx);
        dy = longint'(p.o_cy) - longint'(p.t_cy);
        // Overlap is negative while the boxes intersect on that axis.
        ov_x = ((dx < 0) ? -dx : dx) - (longint'(p.o_hw) + longint'(p.t_hw));
        ov_y = ((dy < 0) ? -dy : dy) - (longint'(p.o_hh) + longint'(p.t_hh));
        r.hit  = 1'b0;
        r.t_mx = '0;
        r.t_my = '0;
        r.o_mx = '0;
        r.o_my = '0;
        r.dir  = aabb_pkg::DIR_NONE;
        if (ov_x < 0 && ov_y < 0)
        begin
            share = (p.push < 0) ? 0 : ((longint'(p.push) > UNIT_W) ? UNIT_W
                                                                     : longint'(p.push));
            keep  = UNIT_W - share;
            r.hit = 1'b1;
            // The shallower axis wins; equal overlaps resolve along y.
            if (ov_x > ov_y)
            begin
                signed_ov = (dx > 0) ? ov_x : -ov_x;
                // An arithmetic right shift of the exact product rounds toward minus infinity.
                mv_this  = (signed_ov * keep) >>> FRAC_BITS;
                mv_other = (-signed_ov * share) >>> FRAC_BITS;
                r.t_mx   = mv_this[MOVE_BITS-1:0];
                r.o_mx   = mv_other[MOVE_BITS-1:0];
                r.dir    = (dx > 0) ? aabb_pkg::DIR_PLUS_X : aabb_pkg::DIR_MINUS_X;
            end
            else
            begin
                signed_ov = (dy > 0) ? ov_y : -ov_y;
                mv_this  = (signed_ov * keep) >>> FRAC_BITS;
                mv_other = (-signed_ov * share) >>> FRAC_BITS;
                r.t_my   = mv_this[MOVE_BITS-1:0];
                r.o_my   = mv_other[MOVE_BITS-1:0];
                r.dir    = (dy > 0) ? aabb_pkg::DIR_PLUS_Y : aabb_pkg::DIR_MINUS_Y;
            end
        end
        return r;
    endfunction

    // Signed value spread over roughly plus or minus 2^(bits-1).
    function automatic logic signed [COORD_BITS-1:0] rand_coord(int bits);
        logic signed [COORD_BITS-1:0] c;
        c = COORD_BITS'($urandom);
        return c >>> (COORD_BITS - bits);
    endfunction

    // Unsigned half size below 2^(bits-1).
    function automatic logic [COORD_BITS-2:0] rand_half(int bits);
        logic [COORD_BITS-2:0] h;
        h = (COORD_BITS-1)'($urandom);
        return h >> (COORD_BITS - bits);
    endfunction

    task automatic add_pair(longint tcx, longint tcy, longint thw, longint thh,
                            longint ocx, longint ocy, longint ohw, longint ohh,
                            longint pw);
        box_pair_t p;
        p.t_cx      = tcx[COORD_BITS-1:0];
        p.t_cy      = tcy[COORD_BITS-1:0];
        p.t_hw      = thw[COORD_BITS-2:0];
        p.t_hh      = thh[COORD_BITS-2:0];
        p.o_cx      = ocx[COORD_BITS-1:0];
        p.o_cy      = ocy[COORD_BITS-1:0];
        p.o_hw      = ohw[COORD_BITS-2:0];
        p.o_hh      = ohh[COORD_BITS-2:0];
        p.push      = pw[aabb_pkg::PUSH_BITS-1:0];
        p.wait_idle = 1'b0;
        pending_pairs.push_back(p);
    endtask

    // Random pairs are mostly scaled so that the boxes tend to intersect, since the
    // split arithmetic is only exercised on a hit. A quarter are raw bit patterns.
    task automatic add_random_pair(bit wait_idle);
        box_pair_t p;
        int        bits;
        int        roll;
        longint    gap;
        roll = $urandom_range(0, 99);
        if (roll < 25)
        begin
            p.t_cx = COORD_BITS'($urandom);
            p.t_cy = COORD_BITS'($urandom);
            p.t_hw = (COORD_BITS-1)'($urandom);
            p.t_hh = (COORD_BITS-1)'($urandom);
            p.o_cx = COORD_BITS'($urandom);
            p.o_cy = COORD_BITS'($urandom);
            p.o_hw = (COORD_BITS-1)'($urandom);
            p.o_hh = (COORD_BITS-1)'($urandom);
        end
        else
        begin
            bits   = $urandom_range(3, COORD_BITS);
            p.t_cx = rand_coord(bits - 1);
            p.t_cy = rand_coord(bits - 1);
            p.o_cx = rand_coord(bits - 1);
            p.o_cy = rand_coord(bits - 1);
            p.t_hw = rand_half(bits);
            p.t_hh = rand_half(bits);
            p.o_hw = rand_half(bits);
            p.o_hh = rand_half(bits);
            roll   = $urandom_range(0, 99);
            if (roll < 15)
            begin
                // Mirror x onto y so both overlaps come out equal.
                p.t_cy = p.t_cx;
                p.o_cy = p.o_cx;
                p.t_hh = p.t_hw;
                p.o_hh = p.o_hw;
            end
            else if (roll < 23)
            begin
                // Boxes that just touch along x.
                gap = longint'(p.o_cx) - longint'(p.t_cx);
                gap = ((gap < 0) ? -gap : gap) - longint'(p.t_hw);
                if (gap >= 0 && gap < (longint'(1) << (COORD_BITS - 1)))
                    p.o_hw = gap[COORD_BITS-2:0];
            end
            else if (roll < 27)
                p.o_cx = p.t_cx;
            else if (roll < 31)
                p.o_cy = p.t_cy;
        end
        if ($urandom_range(0, 99) < 70)
            p.push = aabb_pkg::PUSH_BITS'($urandom_range(0, 256));
        else
            p.push = aabb_pkg::PUSH_BITS'($urandom);
        p.wait_idle = wait_idle;
        pending_pairs.push_back(p);
    endtask

    task automatic note_mismatch(string field, longint want, longint got);
        $error("%s: expected %0d, actual %0d", field, want, got);
        mismatch_count++;
    endtask

    // Driver. A transaction is taken at an edge where in_valid and in_ready were both
    // high; its expected separation is queued right there. The next box pair then
    // goes out unless the sender idles this cycle or the pair must wait for the
    // pipeline to drain. in_valid is assigned at most once per edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready)
            begin
                if (in_valid)
                    expected_moves.push_back(resolve_pair(driven_pair));
                if (pending_pairs.size() > 0
                    && !(($urandom_range(0, 99) < IDLE_PCT)
                         && !(cycle_count >= QUIET_FROM && cycle_count < QUIET_TO))
                    && !(pending_pairs[0].wait_idle && expected_moves.size() > 0))
                begin
                    driven_pair    = pending_pairs.pop_front();
                    this_center_x  <= driven_pair.t_cx;
                    this_center_y  <= driven_pair.t_cy;
                    this_half_w    <= driven_pair.t_hw;
                    this_half_h    <= driven_pair.t_hh;
                    other_center_x <= driven_pair.o_cx;
                    other_center_y <= driven_pair.o_cy;
                    other_half_w   <= driven_pair.o_hw;
                    other_half_h   <= driven_pair.o_hh;
                    push_weight    <= driven_pair.push;
                    in_valid       <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor. Every accepted result is compared field by field with the oldest
    // expectation; out_ready stalls at random outside the quiet window.
    always @(posedge clk)
    begin
        separation_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_moves.size() == 0)
                begin
                    $error("result transaction arrived with no expectation pending");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_moves.pop_front();
                    if (hit !== want.hit)
                        note_mismatch("hit", want.hit, hit);
                    if (this_move_x !== want.t_mx)
                        note_mismatch("this_move_x", want.t_mx, this_move_x);
                    if (this_move_y !== want.t_my)
                        note_mismatch("this_move_y", want.t_my, this_move_y);
                    if (other_move_x !== want.o_mx)
                        note_mismatch("other_move_x", want.o_mx, other_move_x);
                    if (other_move_y !== want.o_my)
                        note_mismatch("other_move_y", want.o_my, other_move_y);
                    if (direction_code !== want.dir)
                        note_mismatch("direction_code", want.dir, direction_code);
                end
            end
            out_ready <= !(($urandom_range(0, 99) < IDLE_PCT)
                           && !(cycle_count >= QUIET_FROM && cycle_count < QUIET_TO));
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        // Directed pairs: no hit, touching, each direction, zero deltas, ties,
        // clamped push weights and the extremes of every field.
        add_pair(0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_pair(0, 0, 1, 1, 0, 0, 1, 1, 128);
        add_pair(0, 0, 256, 256, 100, 0, 256, 256, 64);
        add_pair(0, 0, 256, 256, -100, 0, 256, 256, 64);
        add_pair(0, 0, 256, 256, 0, 100, 256, 256, 200);
        add_pair(0, 0, 256, 256, 0, -100, 256, 256, 200);
        add_pair(50, 50, 10, 1000, 50, 50, 10, 1000, 77);
        add_pair(0, 0, 256, 256, 512, 0, 256, 256, 128);
        add_pair(0, 0, 256, 256, 0, -512, 256, 256, 128);
        add_pair(-4000, 3000, 100, 100, 4000, -3000, 100, 100, 128);
        add_pair(0, 0, 300, 300, 77, -33, 300, 300, -1);
        add_pair(0, 0, 300, 300, -77, 33, 300, 300, 257);
        add_pair(0, 0, 300, 300, 91, 5, 300, 300, -32768);
        add_pair(0, 0, 300, 300, 5, -91, 300, 300, 32767);
        add_pair(0, 0, 300, 300, -13, -12, 300, 300, 256);
        add_pair(0, 0, 300, 300, 13, 12, 300, 300, 0);
        add_pair(8388607, 8388607, 8388607, 8388607,
                 -8388608, -8388608, 8388607, 8388607, 128);
        add_pair(8388607, 8388607, 0, 8388607, 8388607, 8388607, 1, 8388607, 128);
        add_pair(-8388608, -8388608, 8388607, 8388607,
                 -8388608, -8388608, 8388607, 8388607, 3);
        add_pair(-8388608, 8388607, 8388607, 0, 8388607, 8388607, 8388607, 1, 255);
        add_pair(1, 2, 4, 4, 4, 5, 4, 4, 1);
        add_pair(-3, 7, 5, 5, -6, 4, 5, 5, 129);
        // The first random pair waits for the directed results to drain, and so
        // does one in the middle of the random stream.
        for (int n = 0; n < RANDOM_PAIRS; n++)
            add_random_pair(n == 0 || n == RANDOM_PAIRS / 2);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_pairs.size() > 0 || in_valid)
            @(posedge clk);
        while (expected_moves.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
